// File: design/show_pkg.sv
// Shared types and constants for the suffix hash override window.
package show_pkg;

    // Default number of window entries.
    localparam int WINDOW_DEPTH_DEFAULT = 16;

    // Hash and count widths.
    localparam int HASH_W  = 32;
    localparam int COUNT_W = 32;

    // FNV-1a prime for the suffix fold.
    localparam logic [HASH_W-1:0] FOLD_PRIME = 32'd16777619;

    // Fixed suffix bytes, folded in order from index zero.
    localparam int SUFFIX_LEN = 8;
    localparam logic [7:0] SUFFIX_BYTES [SUFFIX_LEN] = '{
        8'h60, 8'h67, 8'h61, 8'h6d, 8'h65, 8'h65, 8'h78, 8'h74
    };

    // Control sequence of the top level.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_DONE
    } ctrl_state_t;

    // Status reported by the fold unit.
    typedef struct packed {
        logic busy;
        logic done;
    } fold_status_t;

endpackage

// File: design/show_fold.sv
// Iterative suffix fold unit: one FNV-1a byte step per cycle.
module show_fold (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [show_pkg::HASH_W-1:0] hash_in,
    output logic [show_pkg::HASH_W-1:0] folded,
    output show_pkg::fold_status_t     status
);
    import show_pkg::*;

    localparam int STEP_W = $clog2(SUFFIX_LEN);

    logic [HASH_W-1:0]   h_reg, h_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [2*HASH_W-1:0] product;

    // One byte step: xor the suffix byte, then multiply by the prime.
    assign product = (h_reg ^ HASH_W'(SUFFIX_BYTES[step_reg])) * FOLD_PRIME;

    always_comb begin
        h_next    = h_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            h_next    = hash_in;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            h_next    = product[HASH_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SUFFIX_LEN - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is cleared by reset; the hash register is payload.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        h_reg <= h_next;
    end

    assign folded      = h_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: design/show_cell.sv
// One window cell: holds a plain and folded hash and compares against the query.
module show_cell #(
    parameter int CNT_W = 5,
    parameter int IDX   = 0
) (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic [show_pkg::HASH_W-1:0] plain_in,
    input  logic [show_pkg::HASH_W-1:0] folded_in,
    input  logic [show_pkg::HASH_W-1:0] query,
    input  logic [CNT_W-1:0]            filled,
    output logic [show_pkg::HASH_W-1:0] plain_out,
    output logic [show_pkg::HASH_W-1:0] folded_out,
    output logic                        match
);
    import show_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [HASH_W-1:0] plain_reg;
    logic [HASH_W-1:0] folded_reg;
    logic              match_reg;

    // Take the neighbor's entry when the window advances.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            plain_reg  <= plain_in;
            folded_reg <= folded_in;
        end
    end

    // Only cells that hold a written entry may report a match.
    always_ff @(posedge aclk) begin
        match_reg <= (filled > IDX_C) && (folded_reg == query);
    end

    assign plain_out  = plain_reg;
    assign folded_out = folded_reg;
    assign match      = match_reg;

endmodule

// File: design/suffix_hash_override_window_top.sv
// Top level of the suffix hash override window: control, cell chain and output register.
// An item with class_present set gets eight fold steps, then its result is committed.
// No new item is taken until then; the commit waits while the output is stalled.
// An item with class_present clear is taken and yields nothing.
// Reset (aresetn low, synchronous) clears the fill count, override count and control;
// window contents stay undefined and are never matched before they are written.
module suffix_hash_override_window_top #(
    parameter int WINDOW_DEPTH = show_pkg::WINDOW_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] property_hash
    input  logic        s_tuser,   // [0] class_present
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] forwarded_hash, [63:32] override_count
    output logic        m_tuser    // [0] was_override
);
    import show_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(WINDOW_DEPTH);

    ctrl_state_t        state_reg, state_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [CNT_W-1:0]   filled_reg, filled_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [HASH_W-1:0]  out_hash_reg, out_hash_next;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_hit_reg, out_hit_next;

    logic               in_xfer;
    logic               fold_start;
    logic [HASH_W-1:0]  fold_value;
    fold_status_t       fold_stat;
    logic               shift_en;

    logic [HASH_W-1:0]       plain_chain  [WINDOW_DEPTH];
    logic [HASH_W-1:0]       folded_chain [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] match_vec;
    logic [WINDOW_DEPTH-1:0] first_hit;
    logic [HASH_W-1:0]       hit_plain;
    logic                    any_hit;

    assign in_xfer = s_tvalid && s_tready;

    // Suffix fold of the incoming hash.
    show_fold u_fold (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fold_start),
        .hash_in (s_tdata[HASH_W-1:0]),
        .folded  (fold_value),
        .status  (fold_stat)
    );

    // Chain of cells, newest entry in cell zero.
    for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
        logic [HASH_W-1:0] plain_src;
        logic [HASH_W-1:0] folded_src;
        if (i == 0) begin : g_head
            assign plain_src  = hash_reg;
            assign folded_src = fold_value;
        end else begin : g_body
            assign plain_src  = plain_chain[i-1];
            assign folded_src = folded_chain[i-1];
        end
        show_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .aclk       (aclk),
            .shift_en   (shift_en),
            .plain_in   (plain_src),
            .folded_in  (folded_src),
            .query      (hash_reg),
            .filled     (filled_reg),
            .plain_out  (plain_chain[i]),
            .folded_out (folded_chain[i]),
            .match      (match_vec[i])
        );
    end

    // Keep only the newest matching cell, then select its plain hash.
    assign first_hit = match_vec & (~match_vec + 1'b1);
    assign any_hit   = |match_vec;

    always_comb begin
        hit_plain = '0;
        for (int k = 0; k < WINDOW_DEPTH; k++) begin
            hit_plain = hit_plain | ({HASH_W{first_hit[k]}} & plain_chain[k]);
        end
    end

    // Sequencer: accept, fold, then commit the result and advance the window.
    always_comb begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        filled_next    = filled_reg;
        total_next     = total_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_hash_next  = out_hash_reg;
        out_count_next = out_count_reg;
        out_hit_next   = out_hit_reg;
        fold_start     = 1'b0;
        shift_en       = 1'b0;
        s_tready       = (state_reg == ST_IDLE);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && s_tuser) begin
                    hash_next  = s_tdata[HASH_W-1:0];
                    fold_start = 1'b1;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                if (fold_stat.done && !fold_stat.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    shift_en       = 1'b1;
                    total_next     = any_hit ? total_reg + 1'b1 : total_reg;
                    out_hash_next  = any_hit ? hit_plain : hash_reg;
                    out_hit_next   = any_hit;
                    out_count_next = total_next;
                    m_tvalid_next  = 1'b1;
                    if (filled_reg < DEPTH_C) begin
                        filled_next = filled_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            filled_reg   <= '0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            filled_reg   <= filled_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        hash_reg      <= hash_next;
        out_hash_reg  <= out_hash_next;
        out_count_reg <= out_count_next;
        out_hit_reg   <= out_hit_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_count_reg, out_hash_reg};
    assign m_tuser  = out_hit_reg;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the suffix hash override window.
`timescale 1ns / 100ps

module tb_top;
    import show_pkg::*;

    localparam int          WIN_DEPTH      = WINDOW_DEPTH_DEFAULT;
    localparam int          DUT_LATENCY    = 10;
    localparam int          RANDOM_ITEMS   = 1480;
    localparam int          DRAIN_EVERY    = 400;
    localparam int          RX_HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT    = 1000000;

    // One result transfer as the block should produce it.
    typedef struct packed {
        logic [HASH_W-1:0]  forwarded_hash;
        logic               was_override;
        logic [COUNT_W-1:0] override_count;
    } forward_rec_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] property_hash
    logic        s_tuser  = 1'b0; // [0] class_present
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;         // [31:0] forwarded_hash, [63:32] override_count
    logic        m_tuser;         // [0] was_override

    suffix_hash_override_window_top #(
        .WINDOW_DEPTH(WIN_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Clock with an 8 ns period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Shadow copy of the window, the write pointer, the fill count and the override count.
    logic [HASH_W-1:0]  win_plain  [WIN_DEPTH];
    logic [HASH_W-1:0]  win_folded [WIN_DEPTH];
    int                 next_slot = 0;
    int                 fill_count = 0;
    logic [COUNT_W-1:0] override_total = '0;

    forward_rec_t pending_forwards[$];
    int           error_count = 0;
    int unsigned  cycle_count = 0;

    // Traffic shaping shared by the sender, the receiver and the tests.
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    bit          rx_hold_req = 1'b0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_gap_left = 0;

    // Carry a hash through the FNV-1a fold of the fixed suffix, one byte per step.
    function automatic logic [HASH_W-1:0] fold_suffix(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] acc;
        acc = h;
        for (int k = 0; k < SUFFIX_LEN; k++) begin
            acc = (acc ^ {24'd0, SUFFIX_BYTES[k]}) * FOLD_PRIME;
        end
        return acc;
    endfunction

    // Plain hash stored age entries back; age 1 is the newest.
    function automatic logic [HASH_W-1:0] recent_plain(input int age);
        return win_plain[(next_slot + WIN_DEPTH - age) % WIN_DEPTH];
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Look a present hash up in the window, newest first, then store it; an absent one is ignored.
    task automatic window_lookup(input logic [HASH_W-1:0] h, input logic present);
        forward_rec_t rec;
        int           idx;
        if (!present) return;
        rec.forwarded_hash = h;
        rec.was_override   = 1'b0;
        for (int i = 1; i <= fill_count && !rec.was_override; i++) begin
            idx = (next_slot + WIN_DEPTH - i) % WIN_DEPTH;
            if (win_folded[idx] == h) begin
                rec.forwarded_hash = win_plain[idx];
                rec.was_override   = 1'b1;
            end
        end
        if (rec.was_override) override_total = override_total + 1'b1;
        rec.override_count = override_total;
        win_plain[next_slot]  = h;
        win_folded[next_slot] = fold_suffix(h);
        next_slot = (next_slot + 1) % WIN_DEPTH;
        if (fill_count < WIN_DEPTH) fill_count++;
        pending_forwards.push_back(rec);
    endtask

    // Offer one item and wait for its transfer; valid stays high when no gap follows.
    task automatic send_item(input logic [HASH_W-1:0] h, input logic present);
        int unsigned gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= h;
        s_tuser  <= present;
        do @(posedge aclk); while (!s_tready);
        window_lookup(h, present);
    endtask

    // Stop offering and wait until every predicted result has been taken.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_forwards.size() != 0) @(posedge aclk);
    endtask

    // Empty window, extreme hashes, absent targets, duplicates and fold chains.
    task automatic test_directed_cases();
        logic [HASH_W-1:0] h;
        h = $urandom();
        send_item(fold_suffix(32'h0000_0000), 1'b1);
        send_item(32'h0000_0000, 1'b1);
        send_item(fold_suffix(32'h0000_0000), 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(fold_suffix(32'hFFFF_FFFF), 1'b1);
        // An absent target must leave the window and the count untouched.
        send_item(fold_suffix(32'hFFFF_FFFF), 1'b0);
        send_item(32'hA5A5_5A5A, 1'b0);
        send_item(fold_suffix(32'hFFFF_FFFF), 1'b1);
        // Two entries with the same folded value; the newer one answers.
        send_item(h, 1'b1);
        send_item(h, 1'b1);
        send_item(fold_suffix(h), 1'b1);
        // The stored fold of h now folds again into a match of its own.
        send_item(fold_suffix(fold_suffix(h)), 1'b1);
        send_item(fold_suffix(h), 1'b1);
        wait_for_results();
    endtask

    // The oldest entry still matches; one more store pushes it out.
    task automatic test_window_edge();
        logic [HASH_W-1:0] h;
        h = $urandom();
        send_item(h, 1'b1);
        repeat (WIN_DEPTH - 1) send_item($urandom(), 1'b1);
        send_item(fold_suffix(h), 1'b1);
        send_item(fold_suffix(h), 1'b1);
        wait_for_results();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering.
    task automatic test_output_stall();
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            if (fill_count != 0 && i % 2 == 1)
                send_item(fold_suffix(recent_plain($urandom_range(1, fill_count))), 1'b1);
            else
                send_item($urandom(), 1'b1);
        end
        tx_steady = 1'b0;
        wait_for_results();
    endtask

    // Mostly matching lookups with random content, mixed with noise and absent targets.
    task automatic test_random_traffic();
        int                sent;
        int                phase_left;
        int                next_drain;
        int unsigned       kind;
        logic [HASH_W-1:0] h;
        sent       = 0;
        phase_left = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RANDOM_ITEMS) begin
            if (phase_left <= 0) begin
                phase_left = $urandom_range(50, 150);
                tx_steady  = ($urandom_range(0, 3) == 0);
                rx_steady  = ($urandom_range(0, 3) == 0);
            end
            if (sent >= next_drain) begin
                next_drain += DRAIN_EVERY;
                wait_for_results();
            end
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                if (fill_count != 0 && kind < 5)
                    h = fold_suffix(recent_plain($urandom_range(1, fill_count)));
                else
                    h = $urandom();
                send_item(h, 1'b0);
            end else begin
                if (kind < 65 && fill_count != 0)
                    h = fold_suffix(recent_plain($urandom_range(1, fill_count)));
                else if (kind < 72 && fill_count != 0)
                    h = recent_plain($urandom_range(1, fill_count));
                else if (kind < 76) begin
                    case ($urandom_range(0, 3))
                        0:       h = 32'h0000_0000;
                        1:       h = 32'hFFFF_FFFF;
                        2:       h = fold_suffix(32'h0000_0000);
                        default: h = 32'h8000_0001;
                    endcase
                end else
                    h = $urandom();
                send_item(h, 1'b1);
                sent++;
            end
            phase_left--;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: a requested long hold first, then random stalls unless steady.
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_req  = 1'b0;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else if (rx_gap_left != 0) begin
            rx_gap_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 2) == 0) rx_gap_left = idle_len();
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge aclk) begin : check_result
        forward_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_forwards.size() == 0) begin
                $display("%0t: unexpected result hash=%h override=%b count=%h",
                         $time, m_tdata[31:0], m_tuser, m_tdata[63:32]);
                error_count++;
            end else begin
                want = pending_forwards.pop_front();
                if (m_tdata[31:0] !== want.forwarded_hash) begin
                    $display("%0t: forwarded_hash expected %h actual %h",
                             $time, want.forwarded_hash, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tuser !== want.was_override) begin
                    $display("%0t: was_override expected %b actual %b",
                             $time, want.was_override, m_tuser);
                    error_count++;
                end
                if (m_tdata[63:32] !== want.override_count) begin
                    $display("%0t: override_count expected %h actual %h",
                             $time, want.override_count, m_tdata[63:32]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Reset once, run the tests in turn, then let the pipeline settle.
    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_window_edge();
        test_output_stall();
        test_random_traffic();
        wait_for_results();
        repeat (4 * DUT_LATENCY) @(posedge aclk);
        if (error_count == 0 && pending_forwards.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
design/show_pkg.sv
design/show_fold.sv
design/show_cell.sv
design/suffix_hash_override_window_top.sv
verif/tb_top.sv
